### hdl/vpfa_pkg.sv
package vpfa_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int SIZE_BITS_DEF    = 10;
  localparam int RESET_MEMORY     = 100;

  localparam int REQ_SIZE_W  = 10;
  localparam int OWNER_W     = 16;
  localparam int TIME_W      = 8;
  localparam int FREE_W      = 10;
  localparam int SEGS_W      = 6;
  localparam int STATUS_W    = 2;
  localparam int POLICY_W    = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 10;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_MEMORY = 8'd1;

  typedef struct packed {
    logic load_in;
    logic scan;
    logic place;
    logic merge;
    logic flush;
    logic sum;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

### hdl/vpfa_ctrl.sv
module vpfa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  vpfa_pkg::dp_status_t st,
  output vpfa_pkg::cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_PLACE = 7'b0000100,
    S_MERGE = 7'b0001000,
    S_FLUSH = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_mode == vpfa_pkg::MODE_TICK) ? S_MERGE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.last) state_nxt = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_SUM;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (st.last) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (st.last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/vpfa_dp.sv
module vpfa_dp #(
  parameter int MAX_SEGMENTS = vpfa_pkg::MAX_SEGMENTS_DEF,
  parameter int SIZE_BITS    = vpfa_pkg::SIZE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vpfa_pkg::cmd_t                      cmd,
  output vpfa_pkg::dp_status_t                st,
  input  logic [vpfa_pkg::REQ_SIZE_W-1:0]     in_req_size,
  input  logic [vpfa_pkg::OWNER_W-1:0]        in_req_owner,
  input  logic [vpfa_pkg::TIME_W-1:0]         in_req_time,
  input  logic                                cfg_we,
  input  logic [vpfa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vpfa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [vpfa_pkg::STATUS_W-1:0]       out_status,
  output logic [vpfa_pkg::FREE_W-1:0]         out_free_total,
  output logic [vpfa_pkg::SEGS_W-1:0]         out_segments_used
);

  localparam int M  = MAX_SEGMENTS;
  localparam int SW = SIZE_BITS;
  localparam int IW = $clog2(M);
  localparam int CW = $clog2(M + 1);
  localparam int OW = vpfa_pkg::OWNER_W;
  localparam int TW = vpfa_pkg::TIME_W;
  localparam int FW = vpfa_pkg::FREE_W;
  localparam int GW = vpfa_pkg::SEGS_W;
  localparam int PW = vpfa_pkg::POLICY_W;
  localparam int XW = vpfa_pkg::STATUS_W;

  logic [SW-1:0] size_r  [M];
  logic [OW-1:0] owner_r [M];
  logic [TW-1:0] time_r  [M];
  logic [CW-1:0] count_r;
  logic [IW-1:0] idx_r;
  logic [PW-1:0] policy_r;

  logic [SW-1:0] rsize_r;
  logic [OW-1:0] rowner_r;
  logic [TW-1:0] rtime_r;
  logic          found_r;
  logic [IW-1:0] pick_r;
  logic [SW-1:0] psize_r;
  logic [XW-1:0] status_r;
  logic [CW-1:0] w_r;
  logic [SW-1:0] acc_size_r;
  logic [OW-1:0] acc_owner_r;
  logic [TW-1:0] acc_time_r;
  logic          acc_valid_r;
  logic [FW-1:0] sum_r;

  logic [SW-1:0] rd_size;
  logic [OW-1:0] rd_owner;
  logic [TW-1:0] rd_time;
  logic          bad_req, cand, take;
  logic [SW-1:0] rest;
  logic          split, place_ok;
  logic [XW-1:0] place_status;
  logic [CW-1:0] pick_p1;
  logic [TW-1:0] dec_time, mg_time;
  logic [OW-1:0] mg_owner;
  logic          mg_join;
  logic [IW-1:0] w_idx;

  assign rd_size  = size_r[idx_r];
  assign rd_owner = owner_r[idx_r];
  assign rd_time  = time_r[idx_r];
  assign st.last  = (CW'(idx_r) == count_r - CW'(1));

  assign bad_req = (rsize_r == '0) || (rowner_r == '0);
  assign cand    = !bad_req && (rd_owner == '0) && (rd_size >= rsize_r);

  always_comb begin
    take = 1'b0;
    if (cand) begin
      if (!found_r) take = 1'b1;
      else if (policy_r == vpfa_pkg::POL_BEST) take = (rd_size < psize_r);
      else if (policy_r == vpfa_pkg::POL_WORST) take = (rd_size > psize_r);
    end
  end

  assign rest    = psize_r - rsize_r;
  assign split   = (rest != '0);
  assign pick_p1 = CW'(pick_r) + CW'(1);

  always_comb begin
    place_ok     = 1'b0;
    place_status = vpfa_pkg::ST_OK;
    if (!found_r) begin
      place_status = vpfa_pkg::ST_NO_FIT;
    end else if (split && (count_r == CW'(M))) begin
      place_status = vpfa_pkg::ST_FULL;
    end else begin
      place_ok = 1'b1;
    end
  end

  assign dec_time = (rd_time != '0) ? rd_time - TW'(1) : rd_time;
  assign mg_time  = (rd_owner != '0) ? dec_time : rd_time;
  assign mg_owner = ((rd_owner != '0) && (dec_time == '0)) ? '0 : rd_owner;
  assign mg_join  = (mg_owner == '0) && acc_valid_r && (acc_owner_r == '0);
  assign w_idx    = w_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= CW'(1);
      size_r[0]  <= SW'(vpfa_pkg::RESET_MEMORY);
      owner_r[0] <= '0;
      time_r[0]  <= '0;
      policy_r   <= vpfa_pkg::POL_BEST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == vpfa_pkg::CFG_FIT_POLICY) begin
          policy_r <= cfg_data[PW-1:0];
        end else if (cfg_index == vpfa_pkg::CFG_TOTAL_MEMORY) begin
          size_r[0]  <= SW'(cfg_data);
          owner_r[0] <= '0;
          time_r[0]  <= '0;
          count_r    <= CW'(1);
        end
      end
      if (cmd.place && place_ok) begin
        if (split) begin
          for (int k = 1; k < M; k++) begin
            if ((CW'(k) > pick_p1) && (CW'(k) <= count_r)) begin
              size_r[k]  <= size_r[k-1];
              owner_r[k] <= owner_r[k-1];
              time_r[k]  <= time_r[k-1];
            end
          end
          size_r[pick_p1[IW-1:0]]  <= rest;
          owner_r[pick_p1[IW-1:0]] <= '0;
          time_r[pick_p1[IW-1:0]]  <= '0;
          count_r <= count_r + CW'(1);
        end
        size_r[pick_r]  <= rsize_r;
        owner_r[pick_r] <= rowner_r;
        time_r[pick_r]  <= rtime_r;
      end
      if ((cmd.merge && !mg_join && acc_valid_r) || cmd.flush) begin
        size_r[w_idx]  <= acc_size_r;
        owner_r[w_idx] <= acc_owner_r;
        time_r[w_idx]  <= acc_time_r;
      end
      if (cmd.flush) count_r <= w_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rsize_r     <= SW'(in_req_size);
      rowner_r    <= in_req_owner;
      rtime_r     <= in_req_time;
      idx_r       <= '0;
      found_r     <= 1'b0;
      status_r    <= vpfa_pkg::ST_OK;
      w_r         <= '0;
      acc_valid_r <= 1'b0;
      sum_r       <= '0;
    end
    if (cmd.scan) begin
      idx_r <= idx_r + IW'(1);
      if (take) begin
        found_r <= 1'b1;
        pick_r  <= idx_r;
        psize_r <= rd_size;
      end
    end
    if (cmd.place) begin
      status_r <= place_status;
      idx_r    <= '0;
    end
    if (cmd.merge) begin
      idx_r <= idx_r + IW'(1);
      if (mg_join) begin
        acc_size_r <= acc_size_r + rd_size;
      end else begin
        if (acc_valid_r) w_r <= w_r + CW'(1);
        acc_size_r  <= rd_size;
        acc_owner_r <= mg_owner;
        acc_time_r  <= mg_time;
        acc_valid_r <= 1'b1;
      end
    end
    if (cmd.flush) idx_r <= '0;
    if (cmd.sum) begin
      idx_r <= idx_r + IW'(1);
      if (rd_owner == '0) sum_r <= sum_r + FW'(rd_size);
    end
    if (cmd.load_out) begin
      out_status        <= status_r;
      out_free_total    <= sum_r;
      out_segments_used <= GW'(count_r);
    end
  end

endmodule

### hdl/variable_partition_fit_allocator_core.sv
// Contiguous segment allocator with first, best or worst fit. Each input
// transfer (allocate or tick) yields one result transfer. For each item,
// one pass over the segment table picks or merges segments one entry per
// cycle, and a second pass sums the free space. The next item is accepted
// while a result still waits on out_stall. cfg_ready is always high;
// write configuration only while idle. Writing total_memory resets the
// table to one free segment.
module variable_partition_fit_allocator_core #(
  parameter int MAX_SEGMENTS = vpfa_pkg::MAX_SEGMENTS_DEF,
  parameter int SIZE_BITS    = vpfa_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [vpfa_pkg::REQ_SIZE_W-1:0]  in_req_size,
  input  logic [vpfa_pkg::OWNER_W-1:0]     in_req_owner,
  input  logic [vpfa_pkg::TIME_W-1:0]      in_req_time,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [vpfa_pkg::STATUS_W-1:0]    out_status,
  output logic [vpfa_pkg::FREE_W-1:0]      out_free_total,
  output logic [vpfa_pkg::SEGS_W-1:0]      out_segments_used,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vpfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vpfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vpfa_pkg::cmd_t       cmd;
  vpfa_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  vpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  vpfa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SIZE_BITS    (SIZE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_req_size       (in_req_size),
    .in_req_owner      (in_req_owner),
    .in_req_time       (in_req_time),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_status        (out_status),
    .out_free_total    (out_free_total),
    .out_segments_used (out_segments_used)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int NSEG = vpfa_pkg::MAX_SEGMENTS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SW = vpfa_pkg::SIZE_BITS_DEF;
  localparam int RW = vpfa_pkg::REQ_SIZE_W;
  localparam int OW = vpfa_pkg::OWNER_W;
  localparam int TW = vpfa_pkg::TIME_W;
  localparam int XW = vpfa_pkg::STATUS_W;
  localparam int FW = vpfa_pkg::FREE_W;
  localparam int GW = vpfa_pkg::SEGS_W;
  localparam int PW = vpfa_pkg::POLICY_W;
  localparam int IW = vpfa_pkg::CFG_INDEX_W;
  localparam int DW = vpfa_pkg::CFG_DATA_W;
  localparam logic [PW-1:0] POL_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_mode;
  logic [RW-1:0] in_req_size;
  logic [OW-1:0] in_req_owner;
  logic [TW-1:0] in_req_time;
  logic out_valid;
  logic out_stall;
  logic [XW-1:0] out_status;
  logic [FW-1:0] out_free_total;
  logic [GW-1:0] out_segments_used;
  logic cfg_valid;
  logic cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  variable_partition_fit_allocator_core dut (.*);

  typedef struct packed {
    logic [XW-1:0] status;
    logic [FW-1:0] free_total;
    logic [GW-1:0] segs;
  } alloc_result_t;

  // shadow allocator state
  logic [PW-1:0] sh_policy;
  logic [DW-1:0] sh_total;
  logic [SW-1:0] sh_size [NSEG];
  logic [OW-1:0] sh_owner [NSEG];
  logic [TW-1:0] sh_time [NSEG];
  int sh_count;

  alloc_result_t expected_results[$];
  int errors = 0;
  bit out_idle_en = 1;
  bit in_idle_en = 1;
  bit hold_out = 0;
  int quiet_cycles = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < NSEG; i++) begin
      sh_size[i] = '0;
      sh_owner[i] = '0;
      sh_time[i] = '0;
    end
    sh_size[0] = sh_total;
    sh_count = 1;
  endfunction

  function automatic logic [XW-1:0] shadow_allocate(
      logic [RW-1:0] sz, logic [OW-1:0] own, logic [TW-1:0] t);
    int pick;
    bit found;
    logic [SW-1:0] rest;
    pick = NSEG;
    found = 0;
    if (sz == 0 || own == 0) return vpfa_pkg::ST_NO_FIT;
    for (int i = 0; i < sh_count; i++) begin
      if (sh_owner[i] != 0 || sh_size[i] < sz) continue;
      if (!found) begin
        pick = i;
        found = 1;
        if (sh_policy == vpfa_pkg::POL_FIRST || sh_policy == POL_SPARE) break;
      end else if (sh_policy == vpfa_pkg::POL_BEST && sh_size[i] < sh_size[pick]) begin
        pick = i;
      end else if (sh_policy == vpfa_pkg::POL_WORST && sh_size[i] > sh_size[pick]) begin
        pick = i;
      end
    end
    if (!found) return vpfa_pkg::ST_NO_FIT;
    rest = sh_size[pick] - sz;
    if (rest != 0) begin
      if (sh_count >= NSEG) return vpfa_pkg::ST_FULL;
      for (int i = sh_count; i > pick + 1; i--) begin
        sh_size[i] = sh_size[i-1];
        sh_owner[i] = sh_owner[i-1];
        sh_time[i] = sh_time[i-1];
      end
      sh_size[pick+1] = rest;
      sh_owner[pick+1] = '0;
      sh_time[pick+1] = '0;
      sh_count++;
    end
    sh_size[pick] = sz;
    sh_owner[pick] = own;
    sh_time[pick] = t;
    return vpfa_pkg::ST_OK;
  endfunction

  function automatic void shadow_tick();
    int w;
    w = 0;
    for (int r = 0; r < sh_count; r++) begin
      if (sh_owner[r] != 0) begin
        if (sh_time[r] != 0) sh_time[r]--;
        if (sh_time[r] == 0) sh_owner[r] = '0;
      end
    end
    for (int r = 0; r < sh_count; r++) begin
      if (sh_owner[r] == 0 && w > 0 && sh_owner[w-1] == 0) begin
        sh_size[w-1] = sh_size[w-1] + sh_size[r];
      end else begin
        sh_size[w] = sh_size[r];
        sh_owner[w] = sh_owner[r];
        sh_time[w] = sh_time[r];
        w++;
      end
    end
    for (int r = w; r < NSEG; r++) begin
      sh_size[r] = '0;
      sh_owner[r] = '0;
      sh_time[r] = '0;
    end
    sh_count = w;
  endfunction

  function automatic alloc_result_t predict_step(logic mode, logic [RW-1:0] sz,
      logic [OW-1:0] own, logic [TW-1:0] t);
    alloc_result_t res;
    logic [FW-1:0] fsum;
    res.status = vpfa_pkg::ST_OK;
    if (mode == vpfa_pkg::MODE_ALLOC) res.status = shadow_allocate(sz, own, t);
    else shadow_tick();
    fsum = '0;
    for (int i = 0; i < sh_count; i++)
      if (sh_owner[i] == 0) fsum = fsum + FW'(sh_size[i]);
    res.free_total = fsum;
    res.segs = sh_count[GW-1:0];
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * NSEG + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == vpfa_pkg::CFG_FIT_POLICY) begin
      sh_policy = val[PW-1:0];
    end else if (idx == vpfa_pkg::CFG_TOTAL_MEMORY) begin
      sh_total = val;
      clear_shadow();
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(logic mode, logic [RW-1:0] sz,
      logic [OW-1:0] own, logic [TW-1:0] t);
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_req_size <= sz;
    in_req_owner <= own;
    in_req_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_step(mode, sz, own, t));
    @(negedge clk);
  endtask

  task automatic send_alloc(int lo, int hi);
    send_item(vpfa_pkg::MODE_ALLOC, RW'($urandom_range(lo, hi)),
              OW'($urandom_range(1, 65535)), TW'($urandom_range(0, 12)));
  endtask

  task automatic test_directed();
    send_item(vpfa_pkg::MODE_ALLOC, 10'd0, 16'd5, 8'd3);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd5, 16'd0, 8'd3);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd1023, 16'hFFFF, 8'hFF);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd20, 16'h0001, 8'd0);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd30, 16'hFFFF, 8'd255);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd10, 16'h5555, 8'd1);
    send_item(vpfa_pkg::MODE_TICK, '0, '0, '0);
    send_item(vpfa_pkg::MODE_TICK, 10'h3FF, 16'hAAAA, 8'hAA);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd50, 16'h1234, 8'd2);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd50, 16'h4321, 8'd2);
    send_item(vpfa_pkg::MODE_TICK, '0, '0, '0);
    send_item(vpfa_pkg::MODE_TICK, '0, '0, '0);
    send_item(vpfa_pkg::MODE_TICK, '0, '0, '0);
    wait_drained();
    write_reg(vpfa_pkg::CFG_TOTAL_MEMORY, 10'd0);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd1, 16'd1, 8'd1);
    send_item(vpfa_pkg::MODE_TICK, '0, '0, '0);
    wait_drained();
    write_reg(vpfa_pkg::CFG_TOTAL_MEMORY, 10'd1023);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd1023, 16'd7, 8'd1);
    send_item(vpfa_pkg::MODE_TICK, '0, '0, '0);
    wait_drained();
    write_reg(8'd2, 10'd77);
    write_reg(8'hFF, 10'h3FF);
  endtask

  task automatic test_policy(logic [PW-1:0] pol, logic [DW-1:0] mem, int n);
    wait_drained();
    write_reg(vpfa_pkg::CFG_FIT_POLICY, DW'(pol));
    write_reg(vpfa_pkg::CFG_TOTAL_MEMORY, mem);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: send_item(vpfa_pkg::MODE_ALLOC, RW'($urandom), OW'($urandom), TW'($urandom));
        1, 2, 3, 4: send_item(vpfa_pkg::MODE_TICK, RW'($urandom), OW'($urandom),
                              TW'($urandom));
        5: send_alloc(1, 1023);
        default: send_alloc(1, (int'(mem) / 8) + 1);
      endcase
    end
  endtask

  task automatic test_table_full();
    wait_drained();
    write_reg(vpfa_pkg::CFG_FIT_POLICY, DW'(vpfa_pkg::POL_FIRST));
    write_reg(vpfa_pkg::CFG_TOTAL_MEMORY, 10'd1000);
    for (int k = 0; k < 34; k++)
      send_item(vpfa_pkg::MODE_ALLOC, 10'd2, OW'(k + 1), 8'd200);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd938, 16'd99, 8'd5);
    send_item(vpfa_pkg::MODE_ALLOC, 10'd1, 16'd98, 8'd5);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_out = 1;
    for (int k = 0; k < 6; k++) send_alloc(1, 30);
    hold_out = 0;
    wait_drained();
  endtask

  task automatic test_no_idle();
    wait_drained();
    in_idle_en = 0;
    out_idle_en = 0;
    write_reg(vpfa_pkg::CFG_FIT_POLICY, DW'(vpfa_pkg::POL_BEST));
    write_reg(vpfa_pkg::CFG_TOTAL_MEMORY, 10'd500);
    for (int k = 0; k < 60; k++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(vpfa_pkg::MODE_TICK, RW'($urandom), OW'($urandom), TW'($urandom));
      else send_alloc(1, 70);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = vpfa_pkg::MODE_ALLOC;
    in_req_size = '0;
    in_req_owner = '0;
    in_req_time = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sh_policy = vpfa_pkg::POL_BEST;
    sh_total = DW'(vpfa_pkg::RESET_MEMORY);
    clear_shadow();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_policy(vpfa_pkg::POL_BEST, 10'd100, 90);
    test_policy(vpfa_pkg::POL_FIRST, 10'd1023, 90);
    test_policy(vpfa_pkg::POL_WORST, 10'd300, 90);
    test_policy(POL_SPARE, 10'd1, 30);
    test_policy(vpfa_pkg::POL_WORST, 10'd64, 60);
    test_table_full();
    test_backpressure();
    test_policy(vpfa_pkg::POL_BEST, 10'd777, 60);
    test_no_idle();
    wait_drained();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
        wait (!hold_out);
      end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_status);
          errors++;
        end
        if (out_free_total !== exp_r.free_total) begin
          $error("free_total exp %0d got %0d", exp_r.free_total, out_free_total);
          errors++;
        end
        if (out_segments_used !== exp_r.segs) begin
          $error("segments_used exp %0d got %0d", exp_r.segs, out_segments_used);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
